// ===== rtl/qpn_pkg.sv =====
package qpn_pkg;

  // scaled magnitudes sit in [2^29, 2^30) for the largest component
  localparam int TGT = 30;
  // sum of four squared 30-bit magnitudes
  localparam int SQW = 62;
  // one result bit per root stage
  localparam int SQ_IT = SQW / 2;
  localparam int NW = SQ_IT;

  // b operand index for Hamilton term [component][term]; a index is the term
  localparam logic [1:0] HT_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // subtract mask per component, bit t for term t
  localparam logic [3:0] HT_SUB [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef struct packed {
    logic [3:0][TGT-1:0] cm;
    logic [3:0]          neg;
    logic                zero;
  } carry_t;

endpackage

// ===== rtl/quaternion_product_normalized_core.sv =====
// Normalized Hamilton product, registered at the output; one transaction per cycle
// sustained while in_stall is low.
// Depth is set by the 31-stage square root and FRAC_BITS+1 restoring divide stages.
// Output side has a one-entry skid, so in_stall is a register.
// Synchronous reset clears valid bits and the skid; payload registers are not reset.
module quaternion_product_normalized_core #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] r_w,
  output logic signed [COMP_WIDTH-1:0] r_x,
  output logic signed [COMP_WIDTH-1:0] r_y,
  output logic signed [COMP_WIDTH-1:0] r_z,
  output logic                         zero_norm
);
  import qpn_pkg::*;

  localparam int CW   = COMP_WIDTH;
  localparam int PW   = 2 * CW;         // one signed product
  localparam int HW   = PW + 1;         // sum of two terms
  localparam int CWD  = PW + 2;         // sum of four terms
  localparam int MW   = PW + 1;         // magnitude of the sum
  localparam int NCH  = (MW + 7) / 8;   // 8-bit chunks for the leading-one search
  localparam int LW   = $clog2(MW + 1);
  localparam int XW   = MW + TGT;
  localparam int QB   = FRAC_BITS + 1;  // quotient never exceeds 2^FRAC_BITS
  localparam int CMPW = TGT + FRAC_BITS + 2;
  localparam int TOT  = 8 + (SQ_IT + 1) + (QB + 1);

  typedef struct packed {
    logic [3:0][CW-1:0] r;
    logic               zero;
  } res_t;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  logic adv;
  logic [TOT-1:0] pv;

  logic signed [CW-1:0] a_in [4];
  logic signed [CW-1:0] b_in [4];

  assign a_in = '{a_w, a_x, a_y, a_z};
  assign b_in = '{b_w, b_x, b_y, b_z};

  // front stages
  logic signed [PW-1:0]  p_r [4][4];
  logic signed [HW-1:0]  h_r [4][2];
  logic signed [CWD-1:0] c_r [4];
  logic [MW-1:0]         m_r [4];
  logic [3:0]            neg_m;
  logic [MW-1:0]         m_k [4];
  logic [3:0]            neg_k;
  logic [NCH-1:0]        nz_k;
  logic [3:0]            loc_k [NCH];
  logic [MW-1:0]         m_l [4];
  logic [3:0]            neg_l;
  logic [LW-1:0]         len_l;
  carry_t                c_n;
  logic [2*TGT-1:0]      sqr_q [4];
  carry_t                c_q;

  // root and divide stages
  logic [SQW-1:0] sq_s   [SQ_IT+1];
  logic [SQW-1:0] sq_res [SQ_IT+1];
  carry_t         sq_c   [SQ_IT+1];
  logic [SQW-1:0] sq_s_next   [SQ_IT];
  logic [SQW-1:0] sq_res_next [SQ_IT];

  logic [CMPW-1:0] dv_rem [QB+1][4];
  logic [QB-1:0]   dv_q   [QB+1][4];
  logic [NW-1:0]   dv_n   [QB+1];
  logic [3:0]      dv_neg [QB+1];
  logic            dv_zero[QB+1];
  logic [CMPW-1:0] dv_rem_next [QB][4];
  logic [QB-1:0]   dv_q_next   [QB][4];

  // output and skid
  logic sk_v;
  res_t sk_d, od, fmt;

  assign adv      = !sk_v;
  assign in_stall = sk_v;

  // leading-one search, first half: per-chunk bit length
  logic [NCH*8-1:0] orp;
  logic [NCH-1:0]   nz_c;
  logic [3:0]       loc_c [NCH];
  always_comb begin
    orp = (NCH*8)'(m_r[0] | m_r[1] | m_r[2] | m_r[3]);
    for (int j = 0; j < NCH; j++) begin
      loc_c[j] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        if (orp[j*8+b]) loc_c[j] = 4'(b + 1);
      end
      nz_c[j] = |orp[j*8 +: 8];
    end
  end

  // second half: pick the highest nonzero chunk
  logic [LW-1:0] len_c;
  always_comb begin
    len_c = '0;
    for (int j = 0; j < NCH; j++) begin
      if (nz_k[j]) len_c = LW'(j * 8) + LW'(loc_k[j]);
    end
  end

  // block shift to put the largest magnitude at 30 bits
  carry_t c_sh;
  always_comb begin
    logic [XW-1:0] ext;
    c_sh.neg  = neg_l;
    c_sh.zero = (len_l == '0);
    for (int i = 0; i < 4; i++) begin
      ext = XW'(m_l[i]);
      if (len_l > LW'(TGT)) c_sh.cm[i] = TGT'(ext >> (len_l - LW'(TGT)));
      else                  c_sh.cm[i] = TGT'(ext << (LW'(TGT) - len_l));
    end
  end

  // one root bit per stage
  always_comb begin
    logic [SQW-1:0] bt;
    logic [SQW-1:0] tr;
    for (int i = 0; i < SQ_IT; i++) begin
      bt = SQW'(1) << (SQW - 2 - 2 * i);
      tr = sq_res[i] + bt;
      if (sq_s[i] >= tr) begin
        sq_s_next[i]   = sq_s[i] - tr;
        sq_res_next[i] = (sq_res[i] >> 1) + bt;
      end else begin
        sq_s_next[i]   = sq_s[i];
        sq_res_next[i] = sq_res[i] >> 1;
      end
    end
  end

  // one quotient bit per stage, MSB first
  always_comb begin
    logic [CMPW-1:0] dsh;
    for (int k = 0; k < QB; k++) begin
      dsh = CMPW'(dv_n[k]) << (QB - 1 - k);
      for (int i = 0; i < 4; i++) begin
        dv_q_next[k][i] = dv_q[k][i];
        if (dv_rem[k][i] >= dsh) begin
          dv_rem_next[k][i] = dv_rem[k][i] - dsh;
          dv_q_next[k][i][QB-1-k] = 1'b1;
        end else begin
          dv_rem_next[k][i] = dv_rem[k][i];
        end
      end
    end
  end

  // saturate, apply sign, force zero product
  always_comb begin
    logic [CW-1:0] mag;
    fmt.zero = dv_zero[QB];
    for (int i = 0; i < 4; i++) begin
      if ((QB+CW)'(dv_q[QB][i]) > (QB+CW)'(CMAX)) mag = CMAX;
      else                                        mag = CW'(dv_q[QB][i]);
      if (dv_zero[QB])         fmt.r[i] = '0;
      else if (dv_neg[QB][i])  fmt.r[i] = -mag;
      else                     fmt.r[i] = mag;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[TOT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int t = 0; t < 4; t++) begin
          p_r[i][t] <= a_in[t] * b_in[HT_B[i][t]];
        end
        for (int h = 0; h < 2; h++) begin
          h_r[i][h] <= (HT_SUB[i][2*h]   ? -HW'(p_r[i][2*h])   : HW'(p_r[i][2*h]))
                     + (HT_SUB[i][2*h+1] ? -HW'(p_r[i][2*h+1]) : HW'(p_r[i][2*h+1]));
        end
        c_r[i]   <= CWD'(h_r[i][0]) + CWD'(h_r[i][1]);
        neg_m[i] <= c_r[i][CWD-1];
        m_r[i]   <= c_r[i][CWD-1] ? MW'(-c_r[i]) : MW'(c_r[i]);
        m_k[i]   <= m_r[i];
        m_l[i]   <= m_k[i];
        sqr_q[i] <= (2*TGT)'(c_n.cm[i]) * (2*TGT)'(c_n.cm[i]);
      end
      neg_k <= neg_m;
      nz_k  <= nz_c;
      loc_k <= loc_c;
      neg_l <= neg_k;
      len_l <= len_c;
      c_n   <= c_sh;
      c_q   <= c_n;

      sq_s[0]   <= SQW'(sqr_q[0]) + SQW'(sqr_q[1]) + SQW'(sqr_q[2]) + SQW'(sqr_q[3]);
      sq_res[0] <= '0;
      sq_c[0]   <= c_q;
      for (int i = 0; i < SQ_IT; i++) begin
        sq_s[i+1]   <= sq_s_next[i];
        sq_res[i+1] <= sq_res_next[i];
        sq_c[i+1]   <= sq_c[i];
      end

      dv_n[0]    <= NW'(sq_res[SQ_IT]);
      dv_neg[0]  <= sq_c[SQ_IT].neg;
      dv_zero[0] <= sq_c[SQ_IT].zero;
      for (int i = 0; i < 4; i++) begin
        dv_rem[0][i] <= (CMPW'(sq_c[SQ_IT].cm[i]) << FRAC_BITS)
                      + CMPW'(NW'(sq_res[SQ_IT]) >> 1);
        dv_q[0][i]   <= '0;
      end
      for (int k = 0; k < QB; k++) begin
        dv_n[k+1]    <= dv_n[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
        for (int i = 0; i < 4; i++) begin
          dv_rem[k+1][i] <= dv_rem_next[k][i];
          dv_q[k+1][i]   <= dv_q_next[k][i];
        end
      end
    end
  end

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (adv && pv[TOT-1]) begin
        sk_v <= 1'b1;
        sk_d <= fmt;
      end
    end else if (sk_v) begin
      out_valid <= 1'b1;
      od        <= sk_d;
      sk_v      <= 1'b0;
    end else begin
      out_valid <= pv[TOT-1];
      od        <= fmt;
    end
  end

  assign r_w       = od.r[0];
  assign r_x       = od.r[1];
  assign r_y       = od.r[2];
  assign r_z       = od.r[3];
  assign zero_norm = od.zero;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FB = 14;
  // pipeline depth of the core
  localparam int LATENCY = FB + 43;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] comp_t;
  typedef struct {
    comp_t w, x, y, z;
  } quat_t;
  typedef struct {
    comp_t w, x, y, z;
    logic  zero;
  } norm_result_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  comp_t a_w = '0, a_x = '0, a_y = '0, a_z = '0;
  comp_t b_w = '0, b_x = '0, b_y = '0, b_z = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  comp_t r_w, r_x, r_y, r_z;
  logic  zero_norm;

  quaternion_product_normalized_core #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
    .zero_norm(zero_norm)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected normalized products, oldest first
  norm_result_t expected_q[$];
  int           fail_count = 0;
  int           send_gap_pct = 0;   // percent of cycles the sender idles
  int           recv_stall_pct = 0; // percent of cycles the receiver stalls
  int           hold_off = 0;       // long receiver hold-off, in cycles
  int           idle_cycles = 0;

  // 64-bit integer square root, 32 restoring stages
  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Hamilton product a*b, block-scaled to 30 bits, divided by its norm
  function automatic norm_result_t normalized_product(quat_t a, quat_t b);
    longint      av[4], bv[4], c[4];
    logic [63:0] mag[4];
    logic [63:0] maxm, sum, n, q;
    logic [63:0] maxmag;
    int          len;
    comp_t       outc[4];
    norm_result_t r;
    av = '{a.w, a.x, a.y, a.z};
    bv = '{b.w, b.x, b.y, b.z};
    c[0] = av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2] - av[3]*bv[3];
    c[1] = av[0]*bv[1] + av[1]*bv[0] + av[2]*bv[3] - av[3]*bv[2];
    c[2] = av[0]*bv[2] - av[1]*bv[3] + av[2]*bv[0] + av[3]*bv[1];
    c[3] = av[0]*bv[3] + av[1]*bv[2] - av[2]*bv[1] + av[3]*bv[0];
    maxm = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm == 0) begin
      r = '{w: '0, x: '0, y: '0, z: '0, zero: 1'b1};
      return r;
    end
    len = 0;
    while (len < 64 && (maxm >> len) != 0) len++;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (len > 30) mag[i] = mag[i] >> (len - 30);
      else          mag[i] = mag[i] << (30 - len);
      sum += mag[i] * mag[i];
    end
    n = root64(sum);
    maxmag = (64'd1 << (CW - 1)) - 1;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << FB) + (n >> 1)) / n;
      if (q > maxmag) q = maxmag;
      outc[i] = (c[i] < 0) ? comp_t'(-q) : comp_t'(q);
    end
    r = '{w: outc[0], x: outc[1], y: outc[2], z: outc[3], zero: 1'b0};
    return r;
  endfunction

  // drive one pair, hold it until accepted, record its expected result;
  // valid stays high after acceptance so pairs can go back to back
  task automatic send_pair(quat_t a, quat_t b);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {a_w, a_x, a_y, a_z} <= {a.w, a.x, a.y, a.z};
    {b_w, b_x, b_y, b_z} <= {b.w, b.x, b.y, b.z};
    expected_q.push_back(normalized_product(a, b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(9))
      0: return comp_t'(16'h8000);
      1: return comp_t'(16'h7fff);
      2: return '0;
      3: return comp_t'($urandom_range(7)) - comp_t'(4);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    return q;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // corners: zero, extremes, units, tiny products, sign mixes
  task automatic test_directed();
    quat_t one, zq, mx, mn, ii, jj, kk, tiny;
    one = '{16'sd16384, 0, 0, 0};
    zq  = '{0, 0, 0, 0};
    mx  = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    mn  = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
    ii  = '{0, 16'sd16384, 0, 0};
    jj  = '{0, 0, 16'sd16384, 0};
    kk  = '{0, 0, 0, 16'sd16384};
    tiny = '{16'sd1, 0, 0, 0};
    send_pair(zq, zq);
    send_pair(one, zq);
    send_pair(zq, mx);
    send_pair(one, one);
    send_pair(mx, mx);
    send_pair(mn, mn);
    send_pair(mx, mn);
    send_pair(mn, mx);
    send_pair(ii, jj);
    send_pair(jj, kk);
    send_pair(kk, ii);
    send_pair(jj, ii);
    // a3*b1 term alone drives y
    send_pair(kk, ii);
    send_pair('{0, 0, 0, -16'sd32768}, '{0, -16'sd32768, 0, 0});
    send_pair(tiny, tiny);
    send_pair('{-16'sd1, 0, 0, 0}, tiny);
    send_pair('{16'sd1, 16'sd1, 0, 0}, '{16'sd1, -16'sd1, 0, 0});
    send_pair('{16'sd3, -16'sd4, 16'sd5, 0}, '{16'sh7fff, 0, 0, 16'sd1});
    send_pair('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
              '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
    send_pair(rand_quat(), rand_quat());
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(rand_quat(), rand_quat());
  endtask

  // receiver holds off long while sender keeps offering, so in_stall rises
  task automatic test_backpressure();
    hold_off = 300;
    test_random(120);
    drain();
  endtask

  // receiver: random stall plus the long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    norm_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result w=%0d x=%0d y=%0d z=%0d", r_w, r_x, r_y, r_z);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (r_w !== e.w) begin $error("r_w exp %0d got %0d", e.w, r_w); fail_count++; end
        if (r_x !== e.x) begin $error("r_x exp %0d got %0d", e.x, r_x); fail_count++; end
        if (r_y !== e.y) begin $error("r_y exp %0d got %0d", e.y, r_y); fail_count++; end
        if (r_z !== e.z) begin $error("r_z exp %0d got %0d", e.z, r_z); fail_count++; end
        if (zero_norm !== e.zero) begin
          $error("zero_norm exp %0b got %0b", e.zero, zero_norm);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_gap_pct = 10; recv_stall_pct = 71;
    test_random(450);
    test_backpressure();
    send_gap_pct = 71; recv_stall_pct = 10;
    test_random(450);
    drain();
    send_gap_pct = 0; recv_stall_pct = 0;
    test_random(450);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== quaternion_product_normalized_core.f =====
rtl/qpn_pkg.sv
rtl/quaternion_product_normalized_core.sv
dv/tb.sv
